FILE: sv/vnu_pkg.sv
// ----------------------------------------------------------------------------
// vnu_pkg: shared types and constants for the vector normalise unit
// Request/result structs, derived widths and the stage records of both chains.
// ----------------------------------------------------------------------------
package vnu_pkg;

    localparam int IN_WIDTH = 32;  // used bits of each component
    localparam int OUT_FRAC = 30;  // fraction bits of the unit components

    localparam int MAG_W = IN_WIDTH;      // magnitude of a signed component
    localparam int SUM_W = 2 * IN_WIDTH;  // sum of squares
    localparam int LEN_W = IN_WIDTH;      // floor square root
    localparam int QW    = OUT_FRAC + 1;  // quotient bits, |q| <= 2^OUT_FRAC
    localparam int LATENCY = 1 + LEN_W + QW + 1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
    } t_vec_req;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic [31:0]        length;
        logic               zero_vector;
    } t_vec_res;

    typedef struct packed {
        logic                      valid;
        logic [2:0]                sign;
        logic [2:0][MAG_W-1:0]     mag;
        logic [SUM_W-1:0]          rad;
        logic [LEN_W:0]            rem;
        logic [LEN_W-1:0]          root;
    } t_sqrt_stage;

    typedef struct packed {
        logic                      valid;
        logic [2:0]                sign;
        logic [LEN_W-1:0]          len;
        logic [2:0]                lsb;
        logic [2:0][LEN_W-1:0]     rem;
        logic [2:0][QW-1:0]        quo;
    } t_div_stage;

endpackage

FILE: sv/vnu_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnu_sqrt_cell: one root bit of the digit-by-digit square root
// Takes two radicand bits, tries {root,01} and registers the updated stage.
// ----------------------------------------------------------------------------
module vnu_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vnu_pkg::t_sqrt_stage i_stage,
    output vnu_pkg::t_sqrt_stage o_stage
);
    localparam int LW = vnu_pkg::LEN_W;
    localparam int SW = vnu_pkg::SUM_W;

    logic [LW+1:0] n_rem_ext;
    logic [LW+1:0] n_trial;
    logic          n_take;
    vnu_pkg::t_sqrt_stage n_stage;

    always_comb begin
        n_rem_ext = {i_stage.rem[LW-1:0], i_stage.rad[SW-1:SW-2]};
        n_trial   = {i_stage.root, 2'b01};
        n_take    = (n_rem_ext >= n_trial);
        n_stage   = i_stage;
        n_stage.rad = {i_stage.rad[SW-3:0], 2'b00};
        if (n_take) begin
            n_stage.rem  = (LW+1)'(n_rem_ext - n_trial);
            n_stage.root = {i_stage.root[LW-2:0], 1'b1};
        end else begin
            n_stage.rem  = (LW+1)'(n_rem_ext);
            n_stage.root = {i_stage.root[LW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage <= '0;
        end else begin
            o_stage <= n_stage;
        end
    end

endmodule

FILE: sv/vnu_div_cell.sv
// ----------------------------------------------------------------------------
// vnu_div_cell: one quotient bit for all three components
// Restoring division step against the shared length, three lanes side by side.
// ----------------------------------------------------------------------------
module vnu_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vnu_pkg::t_div_stage i_stage,
    output vnu_pkg::t_div_stage o_stage
);
    localparam int LW = vnu_pkg::LEN_W;
    localparam int QW = vnu_pkg::QW;

    logic [2:0][LW:0] n_part;
    vnu_pkg::t_div_stage n_stage;

    always_comb begin
        n_stage     = i_stage;
        n_stage.lsb = 3'b000;  // only the first step brings in a dividend bit
        for (int l = 0; l < 3; l++) begin
            n_part[l] = {i_stage.rem[l], i_stage.lsb[l]};
            if (n_part[l] >= {1'b0, i_stage.len}) begin
                n_stage.rem[l] = LW'(n_part[l] - {1'b0, i_stage.len});
                n_stage.quo[l] = {i_stage.quo[l][QW-2:0], 1'b1};
            end else begin
                n_stage.rem[l] = n_part[l][LW-1:0];
                n_stage.quo[l] = {i_stage.quo[l][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage <= '0;
        end else begin
            o_stage <= n_stage;
        end
    end

endmodule

FILE: sv/vector_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector_normalize_unit: fixed-point 2D/3D vector normalisation
// The pipeline has one squaring stage, one cell per root bit, one cell per
// quotient bit and one output register.
// Throughput: one request per cycle; o_busy is never raised, the receiver
// cannot stall. Synchronous active-low reset empties the pipeline.
// ----------------------------------------------------------------------------
module vector_normalize_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  vnu_pkg::t_vec_req i_req,
    output logic              o_done,
    output vnu_pkg::t_vec_res o_res
);
    localparam int W  = vnu_pkg::IN_WIDTH;
    localparam int MW = vnu_pkg::MAG_W;
    localparam int SW = vnu_pkg::SUM_W;
    localparam int LW = vnu_pkg::LEN_W;
    localparam int QW = vnu_pkg::QW;

    // ---- input: sign/magnitude split, 2D mode drops z ----
    logic [2:0][W-1:0]  n_raw;
    logic [2:0]         n_sign;
    logic [2:0][MW-1:0] n_mag;

    always_comb begin
        n_raw[0] = i_req.comp_x[W-1:0];
        n_raw[1] = i_req.comp_y[W-1:0];
        n_raw[2] = i_req.action ? '0 : i_req.comp_z[W-1:0];
        for (int l = 0; l < 3; l++) begin
            n_sign[l] = n_raw[l][W-1];
            n_mag[l]  = n_sign[l] ? MW'(-n_raw[l]) : n_raw[l];
        end
    end

    // ---- squaring stage: one multiplier per lane, registered ----
    logic                   r_sq_valid;
    logic [2:0]             r_sq_sign;
    logic [2:0][MW-1:0]     r_sq_mag;
    logic [2:0][SW-1:0]     r_sq;

    always_ff @(posedge i_clk) begin
        r_sq_sign <= n_sign;
        r_sq_mag  <= n_mag;
        for (int l = 0; l < 3; l++) begin
            r_sq[l] <= SW'(n_mag[l]) * SW'(n_mag[l]);
        end
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else begin
            r_sq_valid <= i_start;
        end
    end

    // ---- square root chain: one root bit per cell ----
    vnu_pkg::t_sqrt_stage sqrt_chain [0:LW];

    always_comb begin
        sqrt_chain[0].valid = r_sq_valid;
        sqrt_chain[0].sign  = r_sq_sign;
        sqrt_chain[0].mag   = r_sq_mag;
        sqrt_chain[0].rad   = r_sq[0] + r_sq[1] + r_sq[2];  // below 2^SW
        sqrt_chain[0].rem   = '0;
        sqrt_chain[0].root  = '0;
    end

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        vnu_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (sqrt_chain[k]),
            .o_stage (sqrt_chain[k+1])
        );
    end

    // ---- division chain: (mag << OUT_FRAC) / length, one bit per cell ----
    // The partial remainder starts at mag >> 1 (below length as mag <= length);
    // the first cell shifts in mag's low bit, later cells shift in zeros.
    vnu_pkg::t_div_stage div_chain [0:QW];

    always_comb begin
        div_chain[0].valid = sqrt_chain[LW].valid;
        div_chain[0].sign  = sqrt_chain[LW].sign;
        div_chain[0].len   = sqrt_chain[LW].root;
        for (int l = 0; l < 3; l++) begin
            div_chain[0].lsb[l] = sqrt_chain[LW].mag[l][0];
            div_chain[0].rem[l] = LW'(sqrt_chain[LW].mag[l] >> 1);
            div_chain[0].quo[l] = '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        vnu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (div_chain[k]),
            .o_stage (div_chain[k+1])
        );
    end

    // ---- output register: sign restore, zero-vector forcing ----
    logic                n_zero;
    logic [2:0][31:0]    n_unit;

    always_comb begin
        n_zero = (div_chain[QW].len == '0);
        for (int l = 0; l < 3; l++) begin
            if (n_zero) begin
                n_unit[l] = '0;
            end else if (div_chain[QW].sign[l]) begin
                n_unit[l] = 32'(-32'(div_chain[QW].quo[l]));
            end else begin
                n_unit[l] = 32'(div_chain[QW].quo[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.unit_x      <= n_unit[0];
        o_res.unit_y      <= n_unit[1];
        o_res.unit_z      <= n_unit[2];
        o_res.length      <= 32'(div_chain[QW].len);
        o_res.zero_vector <= n_zero;
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= div_chain[QW].valid;
        end
    end

    assign o_busy = 1'b0;

endmodule

FILE: sv/vnu_checker.sv
// ----------------------------------------------------------------------------
// vnu_checker: port-level checks for the vector normalise unit
// Timing of results against requests and consistency of the zero flag.
// ----------------------------------------------------------------------------
module vnu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input vnu_pkg::t_vec_res o_res
);
    localparam int LAT = vnu_pkg::LATENCY;

    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_done_has_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT)) else $error("result without request");

    a_zero_outputs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.zero_vector |->
            o_res.length == 32'd0 && o_res.unit_x == 32'sd0 &&
            o_res.unit_y == 32'sd0 && o_res.unit_z == 32'sd0)
        else $error("zero vector with non-zero outputs");

    a_nonzero_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.zero_vector |-> o_res.length != 32'd0)
        else $error("zero length without flag");

endmodule

bind vector_normalize_unit vnu_checker u_vnu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
